[hw/rtl/rc5_pkg.sv]
// Shared types, constants and helpers for the RC5-32 block encryptor.
// Used by the controller, datapath, top level and checker; no dependencies.
`timescale 1ns / 1ps

package rc5_pkg;

  // Default number of full rounds (RC5-32/12/16)
  localparam int RC5_ROUNDS = 12;

  // Key schedule magic constants
  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  // Key register file
  localparam int KEY_WORDS = 4;
  localparam int KEY_IDX_W = 2;

  localparam logic [KEY_IDX_W-1:0] KEY_WORD0_IDX = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_WORD1_IDX = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_WORD2_IDX = 2'd2;
  localparam logic [KEY_IDX_W-1:0] KEY_WORD3_IDX = 2'd3;

  // Input and output words
  typedef struct packed {
    logic [31:0] plain_low;
    logic [31:0] plain_high;
  } plain_t;

  typedef struct packed {
    logic [31:0] cipher_low;
    logic [31:0] cipher_high;
  } cipher_t;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FILL,
    DP_MIX_A,
    DP_MIX_B,
    DP_WHITE_A,
    DP_WHITE_B,
    DP_HALF,
    DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e                 op;
    logic [KEY_IDX_W-1:0]   key_sel;
  } dp_cmd_t;

  // Rotate left by the low five bits of the amount
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} << n;
    return d[63:32];
  endfunction

endpackage

[hw/rtl/rc5_ctrl.sv]
// Sequencer for key expansion and block encryption.
// Drives datapath commands and subkey memory addresses; depends on rc5_pkg.
`timescale 1ns / 1ps

module rc5_ctrl
  import rc5_pkg::*;
#(
  parameter int Rounds = RC5_ROUNDS,
  localparam int TableSize = 2 * Rounds + 2,
  localparam int AddrW = $clog2(TableSize),
  localparam int MixSteps = 3 * TableSize,
  localparam int StepW = $clog2(MixSteps)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic             cfg_we_i,
  output dp_cmd_t          cmd_o,
  output logic [AddrW-1:0] raddr_o,
  output logic [AddrW-1:0] waddr_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILL  = 4'd1;
  localparam logic [3:0] ST_MRD   = 4'd2;
  localparam logic [3:0] ST_MA    = 4'd3;
  localparam logic [3:0] ST_MB    = 4'd4;
  localparam logic [3:0] ST_START = 4'd5;
  localparam logic [3:0] ST_W0    = 4'd6;
  localparam logic [3:0] ST_W1    = 4'd7;
  localparam logic [3:0] ST_HR    = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic [AddrW-1:0] IdxLast  = AddrW'(TableSize - 1);
  localparam logic [StepW-1:0] StepLast = StepW'(MixSteps - 1);

  logic [3:0]           state_q, state_d;
  logic [AddrW-1:0]     idx_q, idx_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [KEY_IDX_W-1:0] j_q, j_d;
  logic                 ready_q, ready_d;
  logic                 outv_q, outv_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = outv_q;

  // Next-state and command decode
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    step_d        = step_q;
    j_d           = j_q;
    ready_d       = ready_q;
    outv_d        = outv_q;
    cmd_o.op      = DP_NOP;
    cmd_o.key_sel = j_q;
    raddr_o       = '0;
    waddr_o       = idx_q;

    if (outv_q && !out_stall_i) begin
      outv_d = 1'b0;
    end
    if (cfg_we_i) begin
      ready_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        raddr_o = '0;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          idx_d    = '0;
          state_d  = ready_q ? ST_W0 : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.op = DP_FILL;
        if (idx_q == IdxLast) begin
          idx_d   = '0;
          step_d  = '0;
          j_d     = '0;
          state_d = ST_MRD;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      ST_MRD: begin
        raddr_o = idx_q;
        state_d = ST_MA;
      end
      ST_MA: begin
        cmd_o.op = DP_MIX_A;
        state_d  = ST_MB;
      end
      ST_MB: begin
        cmd_o.op = DP_MIX_B;
        idx_d    = (idx_q == IdxLast) ? '0 : idx_q + AddrW'(1);
        j_d      = j_q + KEY_IDX_W'(1);
        step_d   = step_q + StepW'(1);
        if (step_q == StepLast) begin
          ready_d = 1'b1;
          state_d = ST_START;
        end else begin
          state_d = ST_MRD;
        end
      end
      ST_START: begin
        raddr_o = '0;
        state_d = ST_W0;
      end
      ST_W0: begin
        cmd_o.op = DP_WHITE_A;
        raddr_o  = AddrW'(1);
        state_d  = ST_W1;
      end
      ST_W1: begin
        cmd_o.op = DP_WHITE_B;
        raddr_o  = AddrW'(2);
        idx_d    = AddrW'(2);
        state_d  = ST_HR;
      end
      ST_HR: begin
        cmd_o.op = DP_HALF;
        raddr_o  = idx_q + AddrW'(1);
        if (idx_q == IdxLast) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      ST_DONE: begin
        if (!outv_q || !out_stall_i) begin
          cmd_o.op = DP_OUT;
          outv_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      j_q     <= '0;
      ready_q <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      j_q     <= j_d;
      ready_q <= ready_d;
      outv_q  <= outv_d;
    end
  end

endmodule

[hw/rtl/rc5_datapath.sv]
// Key registers, subkey memory and the shared round and mixing logic.
// Acts on commands from rc5_ctrl; depends on rc5_pkg.
`timescale 1ns / 1ps

module rc5_datapath
  import rc5_pkg::*;
#(
  parameter int Rounds = RC5_ROUNDS,
  localparam int TableSize = 2 * Rounds + 2,
  localparam int AddrW = $clog2(TableSize)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [AddrW-1:0]     raddr_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic                 cfg_we_i,
  input  logic [KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  plain_t               in_data_i,
  output cipher_t              out_data_o
);

  logic [31:0] key_q [KEY_WORDS];
  logic [31:0] l_q   [KEY_WORDS];
  logic [31:0] mem   [TableSize];
  logic [31:0] rd_q;
  logic [31:0] acc_q;
  logic [31:0] ka_q, kb_q;
  logic [31:0] a_q, b_q;
  cipher_t     out_q;

  logic [31:0] mix_a, sum_b, mix_b, half;
  logic        mem_we;
  logic [31:0] mem_wdata;

  // Mixing and half-round results
  assign mix_a     = rotl32(rd_q + ka_q + kb_q, 5'd3);
  assign sum_b     = ka_q + kb_q;
  assign mix_b     = rotl32(l_q[cmd_i.key_sel] + sum_b, sum_b[4:0]);
  assign half      = rotl32(a_q ^ b_q, b_q[4:0]) + rd_q;
  assign mem_we    = (cmd_i.op == DP_FILL) || (cmd_i.op == DP_MIX_A);
  assign mem_wdata = (cmd_i.op == DP_FILL) ? acc_q : mix_a;

  assign out_data_o = out_q;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        KEY_WORD0_IDX: key_q[0] <= cfg_data_i;
        KEY_WORD1_IDX: key_q[1] <= cfg_data_i;
        KEY_WORD2_IDX: key_q[2] <= cfg_data_i;
        KEY_WORD3_IDX: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Subkey memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr_i] <= mem_wdata;
    end
    rd_q <= mem[raddr_i];
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        a_q   <= in_data_i.plain_low;
        b_q   <= in_data_i.plain_high;
        acc_q <= MAGIC_P;
        ka_q  <= '0;
        kb_q  <= '0;
        for (int i = 0; i < KEY_WORDS; i++) begin
          l_q[i] <= key_q[i];
        end
      end
      DP_FILL:    acc_q <= acc_q + MAGIC_Q;
      DP_MIX_A:   ka_q <= mix_a;
      DP_MIX_B: begin
        kb_q               <= mix_b;
        l_q[cmd_i.key_sel] <= mix_b;
      end
      DP_WHITE_A: a_q <= a_q + rd_q;
      DP_WHITE_B: b_q <= b_q + rd_q;
      DP_HALF: begin
        a_q <= b_q;
        b_q <= half;
      end
      DP_OUT: begin
        out_q.cipher_low  <= a_q;
        out_q.cipher_high <= b_q;
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/rc5_block_encrypt_top.sv]
// RC5-32 encryptor top: whitening then half-rounds per accepted word; no new word is
// taken until its result is out, set by the single shared half-round unit and the
// single-read-port subkey memory. The first word after reset or a key write runs
// key expansion (table fill, mixing steps of read, mix A and mix B, a restart state).
// Reset clears the key registers and the subkeys-valid flag; subkeys are not cleared.
// Depends on rc5_pkg, rc5_ctrl and rc5_datapath.
`timescale 1ns / 1ps

module rc5_block_encrypt_top
  import rc5_pkg::*;
#(
  parameter int Rounds = RC5_ROUNDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  plain_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cipher_t              out_data_o,
  input  logic                 cfg_we_i,
  input  logic [KEY_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int AddrW = $clog2(2 * Rounds + 2);

  dp_cmd_t          cmd;
  logic [AddrW-1:0] raddr, waddr;

  // Sequencer
  rc5_ctrl #(
    .Rounds(Rounds)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_we_i),
    .cmd_o      (cmd),
    .raddr_o    (raddr),
    .waddr_o    (waddr)
  );

  // Datapath
  rc5_datapath #(
    .Rounds(Rounds)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .raddr_i   (raddr),
    .waddr_i   (waddr),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

[hw/rtl/rc5_checker.sv]
// Port-level checks for rc5_block_encrypt_top, attached by bind.
// Depends on rc5_pkg and the top level's ports.
`timescale 1ns / 1ps

module rc5_checker
  import rc5_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input logic    out_stall_i,
  input cipher_t out_data_o
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // Take no word right after one is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("word accepted while busy");

  // Be busy again later while an accepted word is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##26 in_stall_o)
    else $error("busy period too short");

  // Return to idle as a new result appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("not idle after result");

endmodule

bind rc5_block_encrypt_top rc5_checker u_rc5_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

[tb/rc5_cipher_scoreboard_pkg.sv]
// Ciphertext scoreboard for the RC5-32 block encryptor testbench: key copy,
// subkey expansion, block encryption and the queue of ciphertext words due.
// Depends on rc5_pkg for the word types, round count and magic constants.
`timescale 1ns / 1ps

package rc5_cipher_scoreboard_pkg;
  import rc5_pkg::*;

  localparam int SUBKEY_COUNT = 2 * RC5_ROUNDS + 2;
  localparam int MIX_STEPS    = 3 * SUBKEY_COUNT;

  class cipher_scoreboard;
    logic [31:0] key_words [KEY_WORDS];
    logic [31:0] subkeys [SUBKEY_COUNT];
    bit          subkeys_fresh;
    cipher_t     cipher_due [$];
    int          words_checked;
    int          mismatches;

    function new();
      foreach (key_words[n]) key_words[n] = '0;
      subkeys_fresh = 1'b0;
      words_checked = 0;
      mismatches    = 0;
    endfunction

    function logic [31:0] rotate_left(logic [31:0] v, logic [4:0] amt);
      if (amt == 5'd0) return v;
      return (v << amt) | (v >> (6'd32 - amt));
    endfunction

    // Any key write forces a fresh expansion, even with an unchanged value
    function void set_key(logic [KEY_IDX_W-1:0] idx, logic [31:0] value);
      key_words[idx] = value;
      subkeys_fresh  = 1'b0;
    endfunction

    // Build the subkey table from the current key
    function void expand_subkeys();
      logic [31:0] l [KEY_WORDS];
      logic [31:0] a, b, sum_ab;
      int          i, j;
      l = key_words;
      subkeys[0] = MAGIC_P;
      for (int s = 1; s < SUBKEY_COUNT; s++) subkeys[s] = subkeys[s-1] + MAGIC_Q;
      a = '0;
      b = '0;
      i = 0;
      j = 0;
      for (int s = 0; s < MIX_STEPS; s++) begin
        subkeys[i] = rotate_left(subkeys[i] + a + b, 5'd3);
        a          = subkeys[i];
        sum_ab     = a + b;
        l[j]       = rotate_left(l[j] + sum_ab, sum_ab[4:0]);
        b          = l[j];
        i          = (i + 1) % SUBKEY_COUNT;
        j          = (j + 1) % KEY_WORDS;
      end
      subkeys_fresh = 1'b1;
    endfunction

    // Second whitening subkey, used to steer the first rotation amount
    function logic [31:0] subkey_one();
      if (!subkeys_fresh) expand_subkeys();
      return subkeys[1];
    endfunction

    function cipher_t encrypt_block(plain_t w);
      logic [31:0] a, b, t;
      cipher_t     c;
      if (!subkeys_fresh) expand_subkeys();
      a = w.plain_low + subkeys[0];
      b = w.plain_high + subkeys[1];
      for (int k = 2; k < SUBKEY_COUNT; k++) begin
        t = rotate_left(a ^ b, b[4:0]) + subkeys[k];
        a = b;
        b = t;
      end
      c.cipher_low  = a;
      c.cipher_high = b;
      return c;
    endfunction

    function void note_plain(plain_t w);
      cipher_due.push_back(encrypt_block(w));
    endfunction

    // Compare one ciphertext word against the oldest one due
    function void check_cipher(cipher_t got);
      cipher_t want;
      if (cipher_due.size() == 0) begin
        $error("ciphertext word %016h with none due", got);
        mismatches++;
        return;
      end
      want = cipher_due.pop_front();
      words_checked++;
      if (got.cipher_low !== want.cipher_low) begin
        $error("cipher_low: expected %08h, got %08h", want.cipher_low, got.cipher_low);
        mismatches++;
      end
      if (got.cipher_high !== want.cipher_high) begin
        $error("cipher_high: expected %08h, got %08h", want.cipher_high, got.cipher_high);
        mismatches++;
      end
    endfunction

    function int pending();
      return cipher_due.size();
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Testbench top for rc5_block_encrypt_top: key programming, directed and random
// plaintext words, random idling on both sides, ciphertext checked by the scoreboard.
// Depends on rc5_pkg, rc5_cipher_scoreboard_pkg and the encryptor RTL.
`timescale 1ns / 1ps

module tb_top;
  import rc5_pkg::*;
  import rc5_cipher_scoreboard_pkg::*;

  localparam logic [KEY_IDX_W-1:0] KEY_SLOT [KEY_WORDS] =
    '{KEY_WORD0_IDX, KEY_WORD1_IDX, KEY_WORD2_IDX, KEY_WORD3_IDX};
  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 153;
  localparam int HOLD_CYCLES  = 300;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  plain_t               in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  cipher_t              out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [KEY_IDX_W-1:0] cfg_idx_i   = KEY_WORD0_IDX;
  logic [31:0]          cfg_data_i  = '0;

  cipher_scoreboard sb;
  bit               calm       = 1'b0;
  int unsigned      hold_asks  = 0;
  int unsigned      hold_seen  = 0;
  int unsigned      hold_left  = 0;
  int               key_writes = 0;
  int               key_sets   = 0;

  rc5_block_encrypt_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: hold off on request, otherwise stall at random unless calm
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen   <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 23);
    end
  end

  // Note accepted plaintext, check accepted ciphertext
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_plain(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_cipher(out_data_o);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(31);
      3:       return ~(32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Offer one plaintext word, with an occasional gap before it
  task automatic send_pair(input logic [31:0] lo, input logic [31:0] hi);
    plain_t w;
    int     gap;
    w.plain_low  = lo;
    w.plain_high = hi;
    if (!calm && $urandom_range(99) < 23) begin
      gap = $urandom_range(1, 40);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every ciphertext word due has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    // Let the monitor note the last accepted word first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the selected key words back to back; block must be idle
  task automatic write_keys(input logic [31:0] vals [KEY_WORDS],
                            input logic [KEY_WORDS-1:0] mask);
    for (int n = 0; n < KEY_WORDS; n++) begin
      if (mask[n]) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= KEY_SLOT[n];
        cfg_data_i <= vals[n];
        @(posedge clk_i);
        sb.set_key(KEY_SLOT[n], vals[n]);
        key_writes++;
      end
    end
    cfg_we_i <= 1'b0;
    key_sets++;
  endtask

  initial begin
    #6_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    logic [31:0] key_now [KEY_WORDS];
    logic [31:0] base;
    int          fails;
    int          waited;
    sb = new();
    foreach (key_now[n]) key_now[n] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key: field extremes and steered first rotations (b of 0, 32 and 31, so by 0, 0 and 31)
    base = sb.subkey_one();
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0001, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h0000_0001);
    send_pair(32'hA5A5_A5A5, 32'd0 - base);
    send_pair(32'h5A5A_5A5A, 32'd32 - base);
    send_pair(32'h1234_5678, 32'd31 - base);
    drain();

    // All-ones key
    foreach (key_now[n]) key_now[n] = '1;
    write_keys(key_now, 4'hF);
    base = sb.subkey_one();
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'd0 - base);
    send_pair(32'h0000_0000, 32'd31 - base);
    drain();

    // Rewrite one word with its own value: same subkeys after re-expansion
    write_keys(key_now, 4'b0100);
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Change a single key word
    key_now[0] = 32'h0000_0001;
    write_keys(key_now, 4'b0001);
    base = sb.subkey_one();
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hDEAD_BEEF, 32'd0 - base);
    drain();

    // Random phases, each after a key write of its own
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 5)
        0: begin
          foreach (key_now[n]) key_now[n] = $urandom();
          write_keys(key_now, 4'hF);
        end
        1: begin
          foreach (key_now[n]) key_now[n] = '0;
          write_keys(key_now, 4'hF);
        end
        2: begin
          foreach (key_now[n]) key_now[n] = '1;
          write_keys(key_now, 4'hF);
        end
        3: begin
          foreach (key_now[n]) key_now[n] = rand_word();
          write_keys(key_now, 4'($urandom_range(1, 15)));
        end
        default: begin
          foreach (key_now[n]) key_now[n] = 32'h1 << $urandom_range(31);
          write_keys(key_now, 4'hF);
        end
      endcase
      calm <= (ph == 2) || (ph == 5);
      // Hold the receiver off while the sender keeps offering words
      if (ph == 5) hold_asks <= hold_asks + 1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_pair(rand_word(), rand_word());
        // Pause the sender mid-phase until everything is back
        if (ph == 7 && n == PHASE_WORDS / 2) drain();
      end
      drain();
    end
    calm <= 1'b0;

    // Wait out the tail with a bound, then let the outputs settle quietly
    in_valid_i <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    fails = sb.mismatches;
    if (sb.pending() != 0) begin
      $error("%0d ciphertext words never arrived", sb.pending());
      fails++;
    end

    $display("tb_top: %0d blocks checked under %0d key settings, %0d key word writes",
             sb.words_checked, key_sets, key_writes);
    $display("tb_top: covered random idling, one long receiver hold-off and a mid-run drain");
    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
